// ===== rtl/qsld_pkg.sv =====
// Shared types, constants and the dequantization table of the slice decoder.
package qsld_pkg;

    localparam int SAMPLES_PER_SLICE = 20;
    localparam int QUEUE_DEPTH       = 2;
    localparam int ROW_W             = 4;
    localparam int CODE_W            = 3;
    localparam int CODES_W           = 60;
    localparam int HIST_W            = 16;
    localparam int PCM_W             = 20;
    localparam int FRAC_BITS         = 13;

    typedef enum logic [1:0] {
        OP_DECODE = 2'd0,
        OP_LOAD   = 2'd1,
        OP_RESET  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t                   op;
        logic [ROW_W-1:0]          row;
        logic [CODES_W-1:0]        codes;
        logic signed [HIST_W-1:0]  h_old;
        logic signed [HIST_W-1:0]  h_new;
        logic signed [HIST_W-1:0]  w_old;
        logic signed [HIST_W-1:0]  w_new;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic step;
    } back_status_t;

    localparam logic signed [HIST_W-1:0] WEIGHT_OLD_INIT = -16'sd8192;
    localparam logic signed [HIST_W-1:0] WEIGHT_NEW_INIT = 16'sd16384;

    localparam logic signed [15:0] DEQ_TABLE [16][8] = '{
        '{16'sd1,    -16'sd1,    16'sd3,    -16'sd3,    16'sd5,    -16'sd5,
          16'sd7,    -16'sd7},
        '{16'sd5,    -16'sd5,    16'sd18,   -16'sd18,   16'sd32,   -16'sd32,
          16'sd49,   -16'sd49},
        '{16'sd16,   -16'sd16,   16'sd53,   -16'sd53,   16'sd95,   -16'sd95,
          16'sd147,  -16'sd147},
        '{16'sd34,   -16'sd34,   16'sd113,  -16'sd113,  16'sd203,  -16'sd203,
          16'sd315,  -16'sd315},
        '{16'sd63,   -16'sd63,   16'sd210,  -16'sd210,  16'sd378,  -16'sd378,
          16'sd588,  -16'sd588},
        '{16'sd104,  -16'sd104,  16'sd345,  -16'sd345,  16'sd621,  -16'sd621,
          16'sd966,  -16'sd966},
        '{16'sd158,  -16'sd158,  16'sd528,  -16'sd528,  16'sd950,  -16'sd950,
          16'sd1477, -16'sd1477},
        '{16'sd228,  -16'sd228,  16'sd760,  -16'sd760,  16'sd1368, -16'sd1368,
          16'sd2128, -16'sd2128},
        '{16'sd316,  -16'sd316,  16'sd1053, -16'sd1053, 16'sd1895, -16'sd1895,
          16'sd2947, -16'sd2947},
        '{16'sd422,  -16'sd422,  16'sd1405, -16'sd1405, 16'sd2529, -16'sd2529,
          16'sd3934, -16'sd3934},
        '{16'sd548,  -16'sd548,  16'sd1828, -16'sd1828, 16'sd3290, -16'sd3290,
          16'sd5117, -16'sd5117},
        '{16'sd696,  -16'sd696,  16'sd2320, -16'sd2320, 16'sd4176, -16'sd4176,
          16'sd6496, -16'sd6496},
        '{16'sd868,  -16'sd868,  16'sd2893, -16'sd2893, 16'sd5207, -16'sd5207,
          16'sd8099, -16'sd8099},
        '{16'sd1064, -16'sd1064, 16'sd3548, -16'sd3548, 16'sd6386, -16'sd6386,
          16'sd9933, -16'sd9933},
        '{16'sd1286, -16'sd1286, 16'sd4288, -16'sd4288, 16'sd7718, -16'sd7718,
          16'sd12005, -16'sd12005},
        '{16'sd1536, -16'sd1536, 16'sd5120, -16'sd5120, 16'sd9216, -16'sd9216,
          16'sd14336, -16'sd14336}
    };

endpackage

// ===== rtl/qsld_front.sv =====
// Front end: accepts input requests, drops unused opcodes and builds queue commands.
module qsld_front
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // slice_word[63:0], load_history_0[79:64], load_history_1[95:80],
    // load_weight_0[111:96], load_weight_1[127:112]
    input  logic [127:0]         s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]           s_axis_tuser,
    input  logic                 q_ready,
    output logic                 push,
    output qsld_pkg::cmd_t       cmd
);

    qsld_pkg::opcode_t op;

    assign op            = qsld_pkg::opcode_t'(s_axis_tuser);
    assign s_axis_tready = q_ready;

    // An unused opcode is taken from the bus but never reaches the back end.
    assign push = s_axis_tvalid && q_ready && (op != qsld_pkg::OP_NONE);

    always_comb
    begin
        cmd.op    = op;
        cmd.row   = s_axis_tdata[63:60];
        cmd.codes = s_axis_tdata[59:0];
        cmd.h_old = s_axis_tdata[79:64];
        cmd.h_new = s_axis_tdata[95:80];
        cmd.w_old = s_axis_tdata[111:96];
        cmd.w_new = s_axis_tdata[127:112];
    end

endmodule

// ===== rtl/qsld_queue.sv =====
// Two-entry command queue between the front end and the sample engine.
module qsld_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  qsld_pkg::cmd_t  cmd_in,
    output logic            ready,
    output logic            valid,
    output qsld_pkg::cmd_t  cmd_out,
    input  logic            pop
);

    qsld_pkg::cmd_t mem_reg [qsld_pkg::QUEUE_DEPTH];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign ready   = count_reg != 2'(qsld_pkg::QUEUE_DEPTH);
    assign valid   = count_reg != 2'd0;
    assign cmd_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/qsld_back.sv =====
// LMS sample engine and output register: one sample per cycle unless stalled.
module qsld_back
#(
    parameter int SAMPLES_PER_SLICE = qsld_pkg::SAMPLES_PER_SLICE
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  qsld_pkg::cmd_t          q_cmd,
    output logic                    pop,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // pcm_sample[19:0], zero[23:20]
    output logic [23:0]             m_axis_tdata,
    output logic                    m_axis_tlast,
    output qsld_pkg::back_status_t  status
);

    localparam int CNT_W = (SAMPLES_PER_SLICE > 1) ? $clog2(SAMPLES_PER_SLICE) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_SLICE - 1);

    logic                      busy_reg, busy_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [59:0]               codes_reg, codes_next;
    logic [3:0]                row_reg, row_next;
    logic signed [15:0]        h_old_reg, h_old_next;
    logic signed [15:0]        h_new_reg, h_new_next;
    logic signed [15:0]        w_old_reg, w_old_next;
    logic signed [15:0]        w_new_reg, w_new_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [19:0]        pcm_reg, pcm_next;
    logic                      last_reg, last_next;

    logic                      advance;
    logic                      step;
    logic                      slice_last;
    logic [2:0]                code;
    logic signed [15:0]        dq;
    logic signed [15:0]        dt;
    logic signed [31:0]        prod_old;
    logic signed [31:0]        prod_new;
    logic signed [32:0]        dot;
    logic signed [19:0]        pred;
    logic signed [19:0]        sample;

    assign advance    = !out_valid_reg || m_axis_tready;
    assign step       = busy_reg && advance;
    assign slice_last = cnt_reg == LAST_CNT;
    // The next command enters in the same cycle as the last sample is computed.
    assign pop        = q_valid && (!busy_reg || (step && slice_last));

    assign code     = codes_reg[59:57];
    assign dq       = qsld_pkg::DEQ_TABLE[row_reg][code];
    assign dt       = dq >>> 4;
    assign prod_old = w_old_reg * h_old_reg;
    assign prod_new = w_new_reg * h_new_reg;
    assign dot      = {prod_old[31], prod_old} + {prod_new[31], prod_new};
    assign pred     = dot[32:13];
    assign sample   = pred + {{4{dq[15]}}, dq};

    always_comb
    begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        codes_next     = codes_reg;
        row_next       = row_reg;
        h_old_next     = h_old_reg;
        h_new_next     = h_new_reg;
        w_old_next     = w_old_reg;
        w_new_next     = w_new_reg;
        out_valid_next = out_valid_reg;
        pcm_next       = pcm_reg;
        last_next      = last_reg;

        if (step)
        begin
            h_old_next     = h_new_reg;
            h_new_next     = sample[15:0];
            w_old_next     = w_old_reg + (h_old_reg[15] ? -dt : dt);
            w_new_next     = w_new_reg + (h_new_reg[15] ? -dt : dt);
            codes_next     = {codes_reg[56:0], 3'b000};
            cnt_next       = cnt_reg + CNT_W'(1);
            out_valid_next = 1'b1;
            pcm_next       = sample;
            last_next      = slice_last;
            if (slice_last)
            begin
                busy_next = 1'b0;
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // A load or reset popped on the last sample overrides that sample's update.
        if (pop)
        begin
            unique case (q_cmd.op)
                qsld_pkg::OP_DECODE:
                begin
                    busy_next  = 1'b1;
                    cnt_next   = '0;
                    codes_next = q_cmd.codes;
                    row_next   = q_cmd.row;
                end
                qsld_pkg::OP_LOAD:
                begin
                    h_old_next = q_cmd.h_old;
                    h_new_next = q_cmd.h_new;
                    w_old_next = q_cmd.w_old;
                    w_new_next = q_cmd.w_new;
                end
                qsld_pkg::OP_RESET:
                begin
                    h_old_next = '0;
                    h_new_next = '0;
                    w_old_next = qsld_pkg::WEIGHT_OLD_INIT;
                    w_new_next = qsld_pkg::WEIGHT_NEW_INIT;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        codes_reg <= codes_next;
        row_reg   <= row_next;
        pcm_reg   <= pcm_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            h_old_reg     <= '0;
            h_new_reg     <= '0;
            w_old_reg     <= qsld_pkg::WEIGHT_OLD_INIT;
            w_new_reg     <= qsld_pkg::WEIGHT_NEW_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            h_old_reg     <= h_old_next;
            h_new_reg     <= h_new_next;
            w_old_reg     <= w_old_next;
            w_new_reg     <= w_new_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, pcm_reg};
    assign m_axis_tlast  = last_reg;
    assign status.busy   = busy_reg;
    assign status.step   = step;

endmodule

// ===== rtl/qoa_slice_lms_decoder.sv =====
// Slice decoder: front end, two-entry command queue and LMS sample engine.
// Slice path: an accepted request is held in the queue, then in the engine's slice registers;
// each sample goes to the output register. Throughput: one sample per cycle, set by the
// predictor recurrence, while the output is not held; load and reset never set busy.
// Reset: asynchronous, active low; clears the queue, history to zero, weights to -8192/16384.
module qoa_slice_lms_decoder
#(
    parameter int SAMPLES_PER_SLICE = qsld_pkg::SAMPLES_PER_SLICE
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // slice_word[63:0], load_history_0[79:64], load_history_1[95:80],
    // load_weight_0[111:96], load_weight_1[127:112]
    input  logic [127:0]  s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // pcm_sample[19:0], zero[23:20]
    output logic [23:0]   m_axis_tdata,
    output logic          m_axis_tlast
);

    logic                    push;
    qsld_pkg::cmd_t          front_cmd;
    logic                    q_ready;
    logic                    q_valid;
    qsld_pkg::cmd_t          q_cmd;
    logic                    pop;
    qsld_pkg::back_status_t  status;

    qsld_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_ready       (q_ready),
        .push          (push),
        .cmd           (front_cmd)
    );

    qsld_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (front_cmd),
        .ready   (q_ready),
        .valid   (q_valid),
        .cmd_out (q_cmd),
        .pop     (pop)
    );

    qsld_back
    #(
        .SAMPLES_PER_SLICE (SAMPLES_PER_SLICE)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .status        (status)
    );

    // An unused opcode must never be queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == 2'(qsld_pkg::OP_NONE)))
        |-> !push)
        else $error("unused opcode entered the command queue");

    // A new sample only appears after the engine produced one.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(status.step))
        else $error("output became valid without a sample step");

    // A busy engine with an empty output register must produce a sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        (status.busy && !m_axis_tvalid) |-> status.step)
        else $error("sample engine stalled with free output register");

endmodule
